// ----- rtl/mppm_pkg.sv -----
// ----------------------------------------------------------------------------
// mppm_pkg: shared types and constants of the multi-pattern matcher
// Item kinds, status codes and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package mppm_pkg;

  localparam int KindW   = 2;
  localparam int SymbolW = 5;
  localparam int TotalW  = 16;
  localparam int StatusW = 2;
  localparam int StampW  = 16;

  typedef enum logic [KindW-1:0] {
    K_PATTERN = 2'd0,
    K_BUILD   = 2'd1,
    K_TEXT    = 2'd2,
    K_CLEAR   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_PHASE = 2'd2
  } status_e;

endpackage

// ----- rtl/mppm_ram.sv -----
// ----------------------------------------------------------------------------
// mppm_ram: single write port, single read port memory
// The read data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module mppm_ram #(
  parameter int Width = 12,
  parameter int Depth = 4096,
  localparam int Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/multi_pattern_presence_matcher.sv -----
// ----------------------------------------------------------------------------
// multi_pattern_presence_matcher: Aho-Corasick multi-pattern matcher
// Pattern letters grow a trie, a build item links it, text letters are matched.
// ----------------------------------------------------------------------------
// Usage: one input channel (kind, symbol, last) and one result channel
// (match_total, status), both valid/ready. One sequencer drives five memories
// (transitions, failure links, end counts, visit stamps, build queue) and
// handles one transaction at a time; in_ready_o is high only while it idles.
// Each memory has one read port, so a transaction steps through states:
//   a pattern letter reads and may extend the trie, a final one also bumps
//   its node's end count (ST_FULL instead when the table fills); letters of
//   a dropped pattern are absorbed and its final letter answers; a text letter
//   walks the failure chain, stamping new nodes, up to the root or a visited
//   node; build links the root row, then each queued node, then sweeps stamps.
// A stamp wrap on a final text letter sweeps the stamps again. Wrong-phase
// items answer ST_PHASE without memory access. Results pass through an output
// register, so a new transaction is taken while the last result waits; a
// stalled receiver holds up the next result, and the sequencer waits with it.
// Reset and clear-all start a clearing pass over every memory but the build
// queue, during which no transaction is accepted.
// ----------------------------------------------------------------------------
module multi_pattern_presence_matcher #(
  parameter int MAX_NODES  = 4096,
  parameter int ALPHABET   = 26,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mppm_pkg::KindW-1:0]    kind_i,
  input  logic [mppm_pkg::SymbolW-1:0]  symbol_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mppm_pkg::TotalW-1:0]   match_total_o,
  output logic [mppm_pkg::StatusW-1:0]  status_o
);

  localparam int NB  = $clog2(MAX_NODES);
  localparam int SB  = $clog2(ALPHABET);
  localparam int TOT = MAX_NODES * ALPHABET;
  localparam int AB  = $clog2(TOT);
  localparam int CB  = COUNT_BITS;
  localparam int SW  = mppm_pkg::StampW;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_P_GO, S_P_UPD, S_P_END1, S_P_END2,
    S_B_RROOT, S_B_ROOT, S_B_POP, S_B_NOW, S_B_F, S_B_RC, S_B_RC2, S_B_RF,
    S_SWEEP, S_T_GO, S_T_NXT, S_T_CHK, S_T_VIS, S_T_FIN, S_EMIT
  } state_e;

  function automatic logic [AB-1:0] tidx(logic [NB-1:0] node, logic [SB-1:0] s);
    tidx = AB'(node) * AB'(ALPHABET) + AB'(s);
  endfunction

  state_e state_q;
  logic [AB-1:0] cnt_q;
  logic [NB:0]   node_count_q, head_q, tail_q;
  logic [NB-1:0] ins_q, mc_q, now_q, f_q, nxt_q, n_q;
  logic [SB-1:0] sym_q, c_q;
  logic          last_q, built_q, ov_q;
  logic [SW-1:0] qs_q;
  logic [CB-1:0] total_q;
  logic          sweep_pend_q, sweep_build_q;
  logic [CB-1:0] res_total_q;
  mppm_pkg::status_e res_status_q, out_status_q;
  logic          out_valid_q;
  logic [mppm_pkg::TotalW-1:0] out_total_q;

  // Memory ports
  logic          g_we, f_we, e_we, s_we, q_we;
  logic [AB-1:0] g_wa, g_ra;
  logic [NB-1:0] g_wd, g_rd;
  logic [NB-1:0] f_wa, f_ra, f_wd, f_rd;
  logic [NB-1:0] e_wa, e_ra;
  logic [CB-1:0] e_wd, e_rd;
  logic [NB-1:0] s_wa, s_ra;
  logic [SW-1:0] s_wd, s_rd;
  logic [NB-1:0] q_wa, q_ra, q_wd, q_rd;

  logic [CB:0]   sum;
  logic [CB-1:0] total_sat;
  logic [SB-1:0] sym_in;
  logic [SW-1:0] qs_inc;
  logic          pat_full;

  assign sum       = {1'b0, total_q} + {1'b0, e_rd};
  assign total_sat = sum[CB] ? '1 : sum[CB-1:0];
  assign qs_inc    = qs_q + SW'(1);
  assign sym_in    = (32'(symbol_i) >= ALPHABET) ? SB'(ALPHABET - 1) : SB'(symbol_i);
  assign pat_full  = (g_rd == '0) && (node_count_q >= (NB+1)'(MAX_NODES));

  mppm_ram #(.Width(NB), .Depth(TOT)) u_goto (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(g_wd), .raddr_i(g_ra), .rdata_o(g_rd));
  mppm_ram #(.Width(NB), .Depth(MAX_NODES)) u_fail (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra), .rdata_o(f_rd));
  mppm_ram #(.Width(CB), .Depth(MAX_NODES)) u_endc (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra), .rdata_o(e_rd));
  mppm_ram #(.Width(SW), .Depth(MAX_NODES)) u_stamp (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  mppm_ram #(.Width(NB), .Depth(MAX_NODES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(q_ra), .rdata_o(q_rd));

  always_comb begin
    g_we = 1'b0; g_wa = tidx(ins_q, sym_q); g_wd = '0; g_ra = tidx(ins_q, sym_q);
    f_we = 1'b0; f_wa = g_rd; f_wd = '0; f_ra = n_q;
    e_we = 1'b0; e_wa = ins_q; e_wd = '0; e_ra = ins_q;
    s_we = 1'b0; s_wa = n_q; s_wd = qs_q; s_ra = n_q;
    q_we = 1'b0; q_wa = tail_q[NB-1:0]; q_wd = g_rd; q_ra = head_q[NB-1:0];
    unique case (state_q)
      S_CLEAR: begin
        g_we = 1'b1;
        g_wa = cnt_q;
        if (cnt_q < AB'(MAX_NODES)) begin
          f_we = 1'b1; e_we = 1'b1; s_we = 1'b1;
        end
        f_wa = cnt_q[NB-1:0];
        e_wa = cnt_q[NB-1:0];
        s_wa = cnt_q[NB-1:0];
        s_wd = '0;
      end
      S_P_UPD: begin
        g_we = (g_rd == '0) && (node_count_q < (NB+1)'(MAX_NODES));
        g_wd = node_count_q[NB-1:0];
      end
      S_P_END2: begin
        e_we = 1'b1;
        e_wd = (e_rd == '1) ? e_rd : e_rd + CB'(1);
      end
      S_B_RROOT: g_ra = tidx('0, c_q);
      S_B_ROOT: begin
        if (g_rd != '0 && tail_q < (NB+1)'(MAX_NODES)) begin
          f_we = 1'b1; q_we = 1'b1;
        end
      end
      S_B_NOW: f_ra = q_rd;
      S_B_RC:  g_ra = tidx(now_q, c_q);
      S_B_RC2: g_ra = tidx(f_q, c_q);
      S_B_RF: begin
        f_wa = nxt_q;
        f_wd = g_rd;
        q_wd = nxt_q;
        g_wa = tidx(now_q, c_q);
        g_wd = g_rd;
        if (nxt_q != '0) begin
          f_we = 1'b1;
          q_we = tail_q < (NB+1)'(MAX_NODES);
        end else begin
          g_we = 1'b1;
        end
      end
      S_SWEEP: begin
        s_we = 1'b1;
        s_wa = cnt_q[NB-1:0];
        s_wd = '0;
      end
      S_T_GO: g_ra = tidx(mc_q, sym_q);
      S_T_CHK: e_ra = n_q;
      S_T_VIS: s_we = (s_rd != qs_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      cnt_q         <= '0;
      node_count_q  <= (NB+1)'(1);
      head_q        <= '0;
      tail_q        <= '0;
      ins_q         <= '0;
      mc_q          <= '0;
      c_q           <= '0;
      built_q       <= 1'b0;
      ov_q          <= 1'b0;
      qs_q          <= '0;
      total_q       <= '0;
      sweep_pend_q  <= 1'b0;
      sweep_build_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (cnt_q == AB'(TOT - 1)) begin
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + AB'(1);
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            sym_q       <= sym_in;
            last_q      <= last_i;
            res_total_q <= '0;
            unique case (mppm_pkg::kind_e'(kind_i))
              mppm_pkg::K_PATTERN: begin
                if (built_q) begin
                  res_status_q <= mppm_pkg::ST_PHASE;
                  state_q      <= S_EMIT;
                end else if (ov_q) begin
                  if (last_i) begin
                    res_status_q <= mppm_pkg::ST_FULL;
                    ins_q        <= '0;
                    ov_q         <= 1'b0;
                    state_q      <= S_EMIT;
                  end
                end else begin
                  state_q <= S_P_GO;
                end
              end
              mppm_pkg::K_BUILD: begin
                if (built_q) begin
                  res_status_q <= mppm_pkg::ST_PHASE;
                  state_q      <= S_EMIT;
                end else begin
                  head_q  <= '0;
                  tail_q  <= '0;
                  c_q     <= '0;
                  state_q <= S_B_RROOT;
                end
              end
              mppm_pkg::K_TEXT: begin
                if (built_q) begin
                  state_q <= S_T_GO;
                end else begin
                  res_status_q <= mppm_pkg::ST_PHASE;
                  state_q      <= S_EMIT;
                end
              end
              mppm_pkg::K_CLEAR: begin
                cnt_q        <= '0;
                node_count_q <= (NB+1)'(1);
                ins_q        <= '0;
                mc_q         <= '0;
                built_q      <= 1'b0;
                ov_q         <= 1'b0;
                qs_q         <= '0;
                total_q      <= '0;
                state_q      <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_P_GO: state_q <= S_P_UPD;
        S_P_UPD: begin
          if (pat_full) begin
            // A final letter closes the dropped pattern right away.
            ov_q <= !last_q;
          end else if (g_rd == '0) begin
            ins_q        <= node_count_q[NB-1:0];
            node_count_q <= node_count_q + (NB+1)'(1);
          end else begin
            ins_q <= g_rd;
          end
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (pat_full) begin
            res_status_q <= mppm_pkg::ST_FULL;
            ins_q        <= '0;
            state_q      <= S_EMIT;
          end else begin
            state_q <= S_P_END1;
          end
        end
        S_P_END1: state_q <= S_P_END2;
        S_P_END2: begin
          res_status_q <= mppm_pkg::ST_OK;
          ins_q        <= '0;
          state_q      <= S_EMIT;
        end
        S_B_RROOT: state_q <= S_B_ROOT;
        S_B_ROOT: begin
          if (g_rd != '0 && tail_q < (NB+1)'(MAX_NODES)) begin
            tail_q <= tail_q + (NB+1)'(1);
          end
          if (c_q == SB'(ALPHABET - 1)) begin
            state_q <= S_B_POP;
          end else begin
            c_q     <= c_q + SB'(1);
            state_q <= S_B_RROOT;
          end
        end
        S_B_POP: begin
          if (head_q < tail_q) begin
            head_q  <= head_q + (NB+1)'(1);
            state_q <= S_B_NOW;
          end else begin
            cnt_q         <= '0;
            sweep_build_q <= 1'b1;
            state_q       <= S_SWEEP;
          end
        end
        S_B_NOW: begin
          now_q   <= q_rd;
          state_q <= S_B_F;
        end
        S_B_F: begin
          f_q     <= f_rd;
          c_q     <= '0;
          state_q <= S_B_RC;
        end
        S_B_RC: state_q <= S_B_RC2;
        S_B_RC2: begin
          nxt_q   <= g_rd;
          state_q <= S_B_RF;
        end
        S_B_RF: begin
          if (nxt_q != '0 && tail_q < (NB+1)'(MAX_NODES)) begin
            tail_q <= tail_q + (NB+1)'(1);
          end
          if (c_q == SB'(ALPHABET - 1)) begin
            state_q <= S_B_POP;
          end else begin
            c_q     <= c_q + SB'(1);
            state_q <= S_B_RC;
          end
        end
        S_SWEEP: begin
          if (cnt_q == AB'(MAX_NODES - 1)) begin
            qs_q <= SW'(1);
            if (sweep_build_q) begin
              sweep_build_q <= 1'b0;
              built_q       <= 1'b1;
              ins_q         <= '0;
              ov_q          <= 1'b0;
              mc_q          <= '0;
              total_q       <= '0;
              res_total_q   <= '0;
              res_status_q  <= mppm_pkg::ST_OK;
              state_q       <= S_EMIT;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            cnt_q <= cnt_q + AB'(1);
          end
        end
        S_T_GO: state_q <= S_T_NXT;
        S_T_NXT: begin
          mc_q    <= g_rd;
          n_q     <= g_rd;
          state_q <= S_T_CHK;
        end
        S_T_CHK: state_q <= (n_q == '0) ? S_T_FIN : S_T_VIS;
        S_T_VIS: begin
          if (s_rd == qs_q) begin
            state_q <= S_T_FIN;
          end else begin
            total_q <= total_sat;
            n_q     <= f_rd;
            state_q <= S_T_CHK;
          end
        end
        S_T_FIN: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else begin
            res_total_q  <= total_q;
            res_status_q <= mppm_pkg::ST_OK;
            total_q      <= '0;
            mc_q         <= '0;
            qs_q         <= qs_inc;
            sweep_pend_q <= (qs_inc == '0);
            state_q      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_total_q  <= mppm_pkg::TotalW'(res_total_q);
            out_status_q <= res_status_q;
            if (sweep_pend_q) begin
              // The stamp wrapped: clear all visit stamps before the next query.
              sweep_pend_q  <= 1'b0;
              sweep_build_q <= 1'b0;
              cnt_q         <= '0;
              state_q       <= S_SWEEP;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign match_total_o = out_total_q;
  assign status_o      = out_status_q;

endmodule
